[rtl/mrq_pkg.sv]
// Shared constants, operation codes and controller/datapath interface types.
`default_nettype none

package mrq_pkg;

    localparam int NUM_PROCS  = 16;
    localparam int NUM_LEVELS = 5;

    localparam int MODE_W   = 3;
    localparam int PID_W    = 4;
    localparam int LVL_W    = 3;
    localparam int STATUS_W = 2;
    localparam int EMPTY_W  = 5;
    localparam int LINK_W   = PID_W + 1;
    localparam int STEP_W   = $clog2(NUM_PROCS);

    localparam logic [LINK_W-1:0] LINK_NULL = {1'b1, {PID_W{1'b0}}};
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_PROCS - 1);

    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_HIGH   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POP_LEVEL  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
        logic walk;
        logic unlink;
    } dp_cmd_t;

    typedef struct packed {
        logic need_walk;
        logic walk_hit;
        logic walk_end;
    } dp_sts_t;

endpackage

`default_nettype wire

[rtl/mrq_ctrl.sv]
// Sequencer for the ready queue: accept, execute, list walk, unlink, respond.
`default_nettype none

module mrq_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire mrq_pkg::dp_sts_t sts,
    output mrq_pkg::dp_cmd_t      cmd,
    output logic                  busy,
    output logic                  done
);
    import mrq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_UNLINK,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   done_reg;
    logic   done_next;
    logic   accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        cmd.load   = accept;
        cmd.exec   = (state_reg == S_EXEC);
        cmd.walk   = (state_reg == S_WALK);
        cmd.unlink = (state_reg == S_UNLINK);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = sts.need_walk ? S_WALK : S_RESP;
            end
            S_WALK:
            begin
                if (sts.walk_hit)
                    state_next = S_UNLINK;
                else if (sts.walk_end)
                    state_next = S_RESP;
            end
            S_UNLINK:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = accept ? S_EXEC : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next == S_EXEC) || (state_next == S_WALK)
                 || (state_next == S_UNLINK);
        done_next = (state_next == S_RESP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

[rtl/mrq_datapath.sv]
// Level head/tail/occupancy registers, per-process link table and result registers.
`default_nettype none

module mrq_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mrq_pkg::dp_cmd_t                cmd,
    output mrq_pkg::dp_sts_t                     sts,
    input  wire logic [mrq_pkg::MODE_W-1:0]      mode,
    input  wire logic [mrq_pkg::PID_W-1:0]       process_id,
    input  wire logic [mrq_pkg::LVL_W-1:0]       priority_req,
    output logic [mrq_pkg::PID_W-1:0]            taken_id,
    output logic [mrq_pkg::STATUS_W-1:0]         status,
    output logic [mrq_pkg::EMPTY_W-1:0]          empty_levels
);
    import mrq_pkg::*;

    logic [PID_W-1:0]    head_reg [NUM_LEVELS];
    logic [PID_W-1:0]    tail_reg [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] ne_reg;
    logic [LINK_W-1:0]   link_reg [NUM_PROCS];

    logic [MODE_W-1:0]   mode_reg;
    logic [PID_W-1:0]    pid_reg;
    logic [LVL_W-1:0]    lvl_reg;
    logic [PID_W-1:0]    cur_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [PID_W-1:0]    taken_reg;
    logic [STATUS_W-1:0] status_reg;

    logic [LVL_W-1:0]    hi_lvl;
    logic [LVL_W-1:0]    op_lvl;
    logic                lvl_ok;
    logic                op_ok;
    logic                is_push;
    logic                needs_lvl;
    logic                takes_item;
    logic                range_err;
    logic                push_ok;
    logic                do_take;
    logic                need_walk;
    logic                head_hit;
    logic [PID_W-1:0]    sel_head;
    logic [PID_W-1:0]    sel_tail;
    logic                sel_ne;
    logic [PID_W-1:0]    rd_addr;
    logic [LINK_W-1:0]   link_rd;
    logic                link_null;
    logic                walk_hit;
    logic                walk_end;

    always_comb
    begin
        hi_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (ne_reg[i])
                hi_lvl = LVL_W'(i);
        end

        is_push   = (mode_reg == MODE_PUSH_BACK) || (mode_reg == MODE_PUSH_FRONT);
        needs_lvl = is_push || (mode_reg == MODE_REMOVE) || (mode_reg == MODE_POP_LEVEL);
        case (mode_reg) inside
            MODE_POP_HIGH, MODE_REMOVE, MODE_POP_LEVEL: takes_item = 1'b1;
            default:                                    takes_item = 1'b0;
        endcase

        lvl_ok    = {1'b0, lvl_reg} < (LVL_W + 1)'(NUM_LEVELS);
        range_err = needs_lvl && !lvl_ok;
        push_ok   = is_push && !range_err;

        op_lvl = (mode_reg == MODE_POP_HIGH) ? hi_lvl : lvl_reg;
        op_ok  = {1'b0, op_lvl} < (LVL_W + 1)'(NUM_LEVELS);

        sel_head = '0;
        sel_tail = '0;
        sel_ne   = 1'b0;
        if (op_ok)
        begin
            sel_head = head_reg[op_lvl];
            sel_tail = tail_reg[op_lvl];
            sel_ne   = ne_reg[op_lvl];
        end

        head_hit  = (sel_head == pid_reg);
        do_take   = !range_err && sel_ne
                 && ((mode_reg == MODE_POP_HIGH) || (mode_reg == MODE_POP_LEVEL)
                     || ((mode_reg == MODE_REMOVE) && head_hit));
        need_walk = !range_err && sel_ne && (mode_reg == MODE_REMOVE) && !head_hit;

        if (cmd.unlink)
            rd_addr = pid_reg;
        else if (cmd.walk)
            rd_addr = cur_reg;
        else
            rd_addr = sel_head;
        link_rd   = link_reg[rd_addr];
        link_null = link_rd[PID_W];

        walk_hit = !link_null && (link_rd[PID_W-1:0] == pid_reg);
        walk_end = !walk_hit && (link_null || (step_reg == STEP_LAST));
    end

    always_comb
    begin
        sts.need_walk = need_walk;
        sts.walk_hit  = walk_hit;
        sts.walk_end  = walk_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            ne_reg <= '0;
            for (int j = 0; j < NUM_PROCS; j++)
                link_reg[j] <= LINK_NULL;
        end
        else if (cmd.exec && push_ok)
        begin
            if (!sel_ne)
            begin
                head_reg[lvl_reg] <= pid_reg;
                tail_reg[lvl_reg] <= pid_reg;
                ne_reg[lvl_reg]   <= 1'b1;
                link_reg[pid_reg] <= LINK_NULL;
            end
            else if (mode_reg == MODE_PUSH_BACK)
            begin
                link_reg[pid_reg]  <= LINK_NULL;
                link_reg[sel_tail] <= {1'b0, pid_reg};
                tail_reg[lvl_reg]  <= pid_reg;
            end
            else
            begin
                link_reg[pid_reg] <= {1'b0, sel_head};
                head_reg[lvl_reg] <= pid_reg;
            end
        end
        else if (cmd.exec && do_take)
        begin
            link_reg[sel_head] <= LINK_NULL;
            if (link_null)
            begin
                ne_reg[op_lvl]   <= 1'b0;
                head_reg[op_lvl] <= '0;
                tail_reg[op_lvl] <= '0;
            end
            else
            begin
                head_reg[op_lvl] <= link_rd[PID_W-1:0];
            end
        end
        else if (cmd.unlink)
        begin
            link_reg[cur_reg] <= link_rd;
            if (sel_tail == pid_reg)
                tail_reg[lvl_reg] <= cur_reg;
            link_reg[pid_reg] <= LINK_NULL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            pid_reg  <= process_id;
            lvl_reg  <= priority_req;
        end
        if (cmd.exec)
        begin
            cur_reg   <= sel_head;
            step_reg  <= '0;
            taken_reg <= do_take ? sel_head : '0;
            if (range_err)
                status_reg <= ST_RANGE;
            else if (takes_item && !do_take)
                status_reg <= ST_EMPTY;
            else
                status_reg <= ST_DONE;
        end
        if (cmd.walk && !walk_hit)
        begin
            cur_reg  <= link_rd[PID_W-1:0];
            step_reg <= step_reg + 1'b1;
            if (walk_end)
            begin
                taken_reg  <= '0;
                status_reg <= ST_EMPTY;
            end
        end
        if (cmd.unlink)
        begin
            taken_reg  <= pid_reg;
            status_reg <= ST_DONE;
        end
    end

    always_comb
    begin
        empty_levels = '0;
        for (int i = 0; i < EMPTY_W; i++)
        begin
            if (i < NUM_LEVELS)
                empty_levels[i] = !ne_reg[i];
        end
    end

    assign taken_id = taken_reg;
    assign status   = status_reg;

endmodule

`default_nettype wire

[rtl/multilevel_ready_queue.sv]
// Top level of the multilevel ready queue: controller and datapath.
//
// Usage: a command is transferred at a rising edge with start high and busy low.
// mode selects push back, push front, pop highest level, remove a process by
// walking its level's list, or pop a named level; process_id and priority_req
// give the process and the level (0 is the highest priority).
// Each command gives exactly one result on taken_id, status and empty_levels,
// marked by done for a single cycle; the receiver cannot stall it.
// Sequence: push, pop and a remove that hits the head of its level execute and
// then show done. A remove that walks the list visits one link per walk step
// (at most NUM_PROCS links) and then unlinks a match, all through the single
// read port of the link table.
// Flow: busy drops in the cycle done is high, so a new command can be
// transferred then; busy stays high while a command is in progress.
// Reset: every level empty, all links null, no result pending.
`default_nettype none

module multilevel_ready_queue (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [mrq_pkg::MODE_W-1:0]     mode,
    input  wire logic [mrq_pkg::PID_W-1:0]      process_id,
    input  wire logic [mrq_pkg::LVL_W-1:0]      priority_req,
    output logic                                done,
    output logic [mrq_pkg::PID_W-1:0]           taken_id,
    output logic [mrq_pkg::STATUS_W-1:0]        status,
    output logic [mrq_pkg::EMPTY_W-1:0]         empty_levels
);
    import mrq_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    mrq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    mrq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .process_id   (process_id),
        .priority_req (priority_req),
        .taken_id     (taken_id),
        .status       (status),
        .empty_levels (empty_levels)
    );

endmodule

`default_nettype wire

[rtl/mrq_checker.sv]
// Port-level checks for the ready queue and their binding to the top level.
`default_nettype none

module mrq_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic [mrq_pkg::MODE_W-1:0]     mode,
    input wire logic                           done,
    input wire logic [mrq_pkg::PID_W-1:0]      taken_id,
    input wire logic [mrq_pkg::STATUS_W-1:0]   status
);
    import mrq_pkg::*;

    logic accept;

    assign accept = start && !busy;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !done)
        else $error("transfer did not raise busy");

    a_push_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ((mode == MODE_PUSH_BACK) || (mode == MODE_PUSH_FRONT))
            |=> ##1 done)
        else $error("push result not two cycles after transfer");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == ST_DONE) || (status == ST_EMPTY) || (status == ST_RANGE)))
        else $error("undefined status code");

    a_fail_no_taken: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_DONE) |-> (taken_id == '0))
        else $error("failed command reports a taken process");

endmodule

bind multilevel_ready_queue mrq_checker u_mrq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .done     (done),
    .taken_id (taken_id),
    .status   (status)
);

`default_nettype wire
